// ----- src/sha1md_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared types, round constants and controller/datapath interface records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Initial chaining values.
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [6:0]  LAST_ROUND  = 7'd79;
    localparam logic [2:0]  LAST_DIGEST = 3'd4;
    localparam logic [3:0]  LEN_HI_SLOT = 4'd14;
    localparam logic [2:0]  FULL_BYTES  = 3'd4;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } digest_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } ctrl_state_t;

    // Source of the word written into the block buffer.
    typedef enum logic [2:0] {
        SEL_ITEM,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN_HI,
        SEL_LEN_LO
    } push_sel_t;

    typedef struct packed {
        logic      accept;     // input word taken this cycle
        logic      push;       // write a word into the block buffer
        push_sel_t push_sel;
        logic      load_work;  // copy chaining words into working words
        logic      round;      // run one round
        logic [6:0] round_idx;
        logic      add;        // fold working words into chaining words
        logic      emit;       // present one digest word
        logic [2:0] emit_idx;
        logic      restart;    // return to the initial message state
    } ctrl_cmd_t;

    typedef struct packed {
        logic [3:0] slot;       // next free slot in the block buffer
        logic       item_last;  // input word is the final one
        logic       last_full;  // final input word carries four bytes
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/sha1md_ctrl.sv -----
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences buffer writes, padding, the 80 rounds and the digest output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1md_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  sha1md_pkg::dp_status_t  status,
    output sha1md_pkg::ctrl_cmd_t   cmd,
    output logic                    busy
);

    sha1md_pkg::ctrl_state_t state_reg, state_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] emit_reg, emit_next;
    logic       finish_reg, finish_next;
    logic       pad_reg, pad_next;
    logic       lenhi_reg, lenhi_next;
    logic       final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha1md_pkg::ST_IDLE;
            round_reg  <= '0;
            emit_reg   <= '0;
            finish_reg <= 1'b0;
            pad_reg    <= 1'b0;
            lenhi_reg  <= 1'b0;
            final_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            emit_reg   <= emit_next;
            finish_reg <= finish_next;
            pad_reg    <= pad_next;
            lenhi_reg  <= lenhi_next;
            final_reg  <= final_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        emit_next   = emit_reg;
        finish_next = finish_reg;
        pad_next    = pad_reg;
        lenhi_next  = lenhi_reg;
        final_next  = final_reg;

        cmd           = '0;
        cmd.push_sel  = sha1md_pkg::SEL_ITEM;
        cmd.round_idx = round_reg;
        cmd.emit_idx  = emit_reg;

        busy = (state_reg != sha1md_pkg::ST_IDLE);

        case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept   = 1'b1;
                    cmd.push     = 1'b1;
                    cmd.push_sel = sha1md_pkg::SEL_ITEM;
                    if (status.item_last)
                    begin
                        finish_next = 1'b1;
                        pad_next    = status.last_full;
                    end
                    if (status.slot == 4'hF)
                    begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        state_next    = sha1md_pkg::ST_ROUND;
                    end
                    else if (status.item_last)
                    begin
                        state_next = sha1md_pkg::ST_FILL;
                    end
                end
            end

            sha1md_pkg::ST_FILL:
            begin
                cmd.push = 1'b1;
                if (pad_reg)
                begin
                    cmd.push_sel = sha1md_pkg::SEL_PAD;
                    pad_next     = 1'b0;
                end
                else if (status.slot == sha1md_pkg::LEN_HI_SLOT)
                begin
                    cmd.push_sel = sha1md_pkg::SEL_LEN_HI;
                    lenhi_next   = 1'b1;
                end
                else if (lenhi_reg)
                begin
                    cmd.push_sel = sha1md_pkg::SEL_LEN_LO;
                    final_next   = 1'b1;
                end
                else
                begin
                    cmd.push_sel = sha1md_pkg::SEL_ZERO;
                end
                if (status.slot == 4'hF)
                begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    state_next    = sha1md_pkg::ST_ROUND;
                end
            end

            sha1md_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (round_reg == sha1md_pkg::LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = sha1md_pkg::ST_ADD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end

            sha1md_pkg::ST_ADD:
            begin
                cmd.add = 1'b1;
                if (final_reg)
                begin
                    emit_next  = '0;
                    state_next = sha1md_pkg::ST_EMIT;
                end
                else if (finish_reg)
                begin
                    state_next = sha1md_pkg::ST_FILL;
                end
                else
                begin
                    state_next = sha1md_pkg::ST_IDLE;
                end
            end

            sha1md_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (emit_reg == sha1md_pkg::LAST_DIGEST)
                begin
                    cmd.restart = 1'b1;
                    emit_next   = '0;
                    finish_next = 1'b0;
                    pad_next    = 1'b0;
                    lenhi_next  = 1'b0;
                    final_next  = 1'b0;
                    state_next  = sha1md_pkg::ST_IDLE;
                end
                else
                begin
                    emit_next = emit_reg + 3'd1;
                end
            end

            default:
            begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/sha1md_datapath.sv -----
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer with message schedule, round logic, chaining words and length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1md_datapath (
    input  wire                     clk,
    input  wire                     rst_n,
    input  sha1md_pkg::item_t       item,
    input  sha1md_pkg::ctrl_cmd_t   cmd,
    output sha1md_pkg::dp_status_t  status,
    output sha1md_pkg::digest_t     digest,
    output logic                    digest_strobe
);

    logic [31:0] window_reg [16];
    logic [31:0] chain_reg  [5];
    logic [31:0] work_reg   [5];
    logic [63:0] length_reg;
    logic [3:0]  slot_reg;
    sha1md_pkg::digest_t out_reg;
    logic        strobe_reg;

    logic [2:0]  nb_sat;
    logic [31:0] item_word;
    logic [31:0] push_word;
    logic [31:0] sched_next;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] temp;
    logic [31:0] init_val [5];

    assign init_val[0] = sha1md_pkg::H0_INIT;
    assign init_val[1] = sha1md_pkg::H1_INIT;
    assign init_val[2] = sha1md_pkg::H2_INIT;
    assign init_val[3] = sha1md_pkg::H3_INIT;
    assign init_val[4] = sha1md_pkg::H4_INIT;

    assign nb_sat = (item.valid_bytes > sha1md_pkg::FULL_BYTES) ?
                    sha1md_pkg::FULL_BYTES : item.valid_bytes;

    assign status.slot      = slot_reg;
    assign status.item_last = item.last_word;
    assign status.last_full = (nb_sat == sha1md_pkg::FULL_BYTES);

    // A short final word keeps its valid bytes and takes the pad byte next.
    always_comb
    begin
        if (!item.last_word)
        begin
            item_word = item.data_word;
        end
        else
        begin
            case (nb_sat)
                3'd0: item_word = {sha1md_pkg::PAD_BYTE, 24'h0};
                3'd1: item_word = {item.data_word[31:24], sha1md_pkg::PAD_BYTE, 16'h0};
                3'd2: item_word = {item.data_word[31:16], sha1md_pkg::PAD_BYTE, 8'h0};
                3'd3: item_word = {item.data_word[31:8], sha1md_pkg::PAD_BYTE};
                default: item_word = item.data_word;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.push_sel)
            sha1md_pkg::SEL_ITEM:   push_word = item_word;
            sha1md_pkg::SEL_PAD:    push_word = {sha1md_pkg::PAD_BYTE, 24'h0};
            sha1md_pkg::SEL_LEN_HI: push_word = length_reg[63:32];
            sha1md_pkg::SEL_LEN_LO: push_word = length_reg[31:0];
            default:                push_word = 32'h0;
        endcase
    end

    // The oldest buffered word is the current schedule word; each round
    // shifts in the schedule word sixteen rounds ahead.
    logic [31:0] sched_mix;
    assign sched_mix  = window_reg[13] ^ window_reg[8] ^ window_reg[2] ^ window_reg[0];
    assign sched_next = {sched_mix[30:0], sched_mix[31]};

    always_comb
    begin
        if (cmd.round_idx < 7'd20)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_val = sha1md_pkg::K0;
        end
        else if (cmd.round_idx < 7'd40)
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = sha1md_pkg::K1;
        end
        else if (cmd.round_idx < 7'd60)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3]) |
                    (work_reg[2] & work_reg[3]);
            k_val = sha1md_pkg::K2;
        end
        else
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = sha1md_pkg::K3;
        end
    end

    assign temp = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4] +
                  window_reg[0] + k_val;

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[15] <= cmd.push ? push_word : sched_next;
        end
        if (cmd.emit)
        begin
            out_reg.digest_word <= chain_reg[cmd.emit_idx];
            out_reg.digest_last <= (cmd.emit_idx == sha1md_pkg::LAST_DIGEST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= init_val[i];
                work_reg[i]  <= '0;
            end
            length_reg <= '0;
            slot_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.accept)
            begin
                if (item.last_word)
                begin
                    length_reg <= length_reg + {58'h0, nb_sat, 3'b000};
                end
                else
                begin
                    length_reg <= length_reg + 64'd32;
                end
            end
            if (cmd.push)
            begin
                slot_reg <= slot_reg + 4'd1;
            end
            if (cmd.load_work)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    work_reg[i] <= chain_reg[i];
                end
            end
            else if (cmd.round)
            begin
                work_reg[4] <= work_reg[3];
                work_reg[3] <= work_reg[2];
                work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
                work_reg[1] <= work_reg[0];
                work_reg[0] <= temp;
            end
            if (cmd.add)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            else if (cmd.restart)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_reg[i] <= init_val[i];
                end
                length_reg <= '0;
                slot_reg   <= '0;
            end
        end
    end

    assign digest        = out_reg;
    assign digest_strobe = strobe_reg;

endmodule

`default_nettype wire

// ----- src/sha1_message_digest_top.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest top level
// Streams a message in 32-bit words and returns the 160-bit digest.
// ----------------------------------------------------------------------------
// A message arrives as big-endian words, first byte in bits 31 to 24. A word
// is taken on a rising edge where start is high and busy is low. Only the word
// marked last_word may be partial; its valid_bytes gives the count of leading
// bytes (values above four count as four, and zero is allowed, so an empty
// message is one last word with no bytes). A word that does not fill the
// block buffer leaves busy low unless it is the last word. The word that
// fills the sixteenth slot starts a compression: 80 rounds, one per cycle
// in the shared round unit, then an add into the chaining words, with busy
// high throughout. After the last word the controller writes any pad word,
// zero fill and 64-bit length one word per cycle outside compressions,
// running one or two final compressions, then presents the digest as five
// back-to-back words, H0 first, with digest_last high on the fifth. Each
// digest word is on the digest port for exactly one cycle while digest_strobe
// is high, and the receiver cannot stall it, so it must capture every strobed
// word. Once the digest is out the block is ready for a new message.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest_top (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  sha1md_pkg::item_t    item,
    output logic                 busy,
    output sha1md_pkg::digest_t  digest,
    output logic                 digest_strobe
);

    // The controller issues commands and holds sequencing flags; the data lives
    // in the datapath, which reports the buffer slot and the kind of input word.
    sha1md_pkg::ctrl_cmd_t  cmd;
    sha1md_pkg::dp_status_t status;

    sha1md_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sha1md_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .status        (status),
        .digest        (digest),
        .digest_strobe (digest_strobe)
    );

endmodule

`default_nettype wire

// ----- dv/sha1_message_digest_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest checker
// Watches the word and digest ports, predicts each digest and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_digest_checker
    import sha1md_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  digest_t digest,
    input  logic    digest_strobe,
    output int      fail_count,
    output int      digests_pending
);

    logic [31:0] hash_words [5];
    logic [31:0] block_words [16];
    logic [63:0] msg_bits;
    logic [3:0]  fill_idx;
    digest_t     digests_due [$];
    digest_t     want;
    int          mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic restart_message();
        hash_words[0] = H0_INIT;
        hash_words[1] = H1_INIT;
        hash_words[2] = H2_INIT;
        hash_words[3] = H3_INIT;
        hash_words[4] = H4_INIT;
        msg_bits = '0;
        fill_idx = '0;
    endtask

    // Eighty rounds over the buffered block; the schedule is expanded in place.
    task automatic fold_block();
        logic [31:0] a, b, c, d, e, f, k, t;
        int s;
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (int r = 0; r < 80; r++)
        begin
            s = r % 16;
            if (r >= 16)
                block_words[s] = rol(block_words[(r + 13) % 16] ^ block_words[(r + 8) % 16] ^
                                     block_words[(r + 2) % 16] ^ block_words[s], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rol(a, 5) + f + e + block_words[s] + k;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endtask

    task automatic append_word(input logic [31:0] w);
        block_words[fill_idx] = w;
        fill_idx = fill_idx + 4'd1;
        if (fill_idx == 4'd0)
            fold_block();
    endtask

    task automatic absorb_item(input item_t it);
        int          nbytes;
        logic [31:0] tail;
        if (!it.last_word)
        begin
            msg_bits += 64'd32;
            append_word(it.data_word);
            return;
        end
        nbytes = (it.valid_bytes > FULL_BYTES) ? int'(FULL_BYTES) : int'(it.valid_bytes);
        msg_bits += 64'(nbytes * 8);
        if (nbytes < 4)
        begin
            tail = (nbytes == 0) ? 32'd0 : (it.data_word & (32'hFFFFFFFF << (32 - 8 * nbytes)));
            tail |= {PAD_BYTE, 24'd0} >> (8 * nbytes);
            append_word(tail);
        end
        else
        begin
            append_word(it.data_word);
            append_word({PAD_BYTE, 24'd0});
        end
        while (fill_idx != LEN_HI_SLOT)
            append_word(32'd0);
        append_word(msg_bits[63:32]);
        append_word(msg_bits[31:0]);
        for (int i = 0; i < 5; i++)
            digests_due.push_back('{digest_word: hash_words[i], digest_last: (i == 4)});
        restart_message();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            digests_due.delete();
        end
        else
        begin
            if (digest_strobe)
            begin
                if (digests_due.size() == 0)
                begin
                    $display("%0t: unexpected digest word %08h last %0b", $time,
                             digest.digest_word, digest.digest_last);
                    mismatches++;
                end
                else
                begin
                    want = digests_due.pop_front();
                    if (digest.digest_word !== want.digest_word)
                    begin
                        $display("%0t: digest_word expected %08h actual %08h", $time,
                                 want.digest_word, digest.digest_word);
                        mismatches++;
                    end
                    if (digest.digest_last !== want.digest_last)
                    begin
                        $display("%0t: digest_last expected %0b actual %0b", $time,
                                 want.digest_last, digest.digest_last);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                absorb_item(item);
        end
        digests_pending = digests_due.size();
    end

endmodule

// ----- dv/sha1_message_digest_top_tb.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams directed and random messages into the digest block and checks
// every digest word against an independent prediction in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_digest_top_tb;

    import sha1md_pkg::*;

    // A stretch with no accepted word and no digest word longer than this
    // means the block has hung. A two-block finish and the short sender gaps
    // stay well inside this limit.
    localparam int HANG_LIMIT = 4000;
    // Random words are spread over four phases; each phase ends on a whole
    // message, so the total runs a little past this figure.
    localparam int RANDOM_WORDS = 360;

    logic    clk;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    digest_t digest;
    logic    digest_strobe;
    int      fail_count;
    int      digests_pending;

    int idle_pct;
    int words_sent;
    int quiet_cycles = 0;

    sha1_message_digest_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .busy          (busy),
        .digest        (digest),
        .digest_strobe (digest_strobe)
    );

    // The checker sees exactly what the block sees and reports mismatches.
    sha1_message_digest_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .digest          (digest),
        .digest_strobe   (digest_strobe),
        .fail_count      (fail_count),
        .digests_pending (digests_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offers one word. The task is entered at a falling edge and leaves at the
    // falling edge after the word was taken, so start stays high between
    // back-to-back words without ever being lowered and raised in one step.
    // Idle cycles put random junk on the item port to show it is ignored.
    task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                             input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            item  <= '{data_word: $urandom, valid_bytes: 3'($urandom),
                       last_word: 1'($urandom)};
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= '{data_word: data, valid_bytes: nbytes, last_word: last};
        do
            @(posedge clk);
        while (busy);
        words_sent++;
        @(negedge clk);
    endtask

    // Random body data leans on all-ones and all-zeros now and then. The
    // byte count of a body word is ignored, so it is random as well.
    function automatic logic [31:0] body_data();
        case ($urandom_range(7))
            0:       return 32'hFFFFFFFF;
            1:       return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_message(input int body_words, input logic [2:0] tail_bytes);
        for (int i = 0; i < body_words; i++)
            send_word(body_data(), 3'($urandom), 1'b0);
        send_word(body_data(), tail_bytes, 1'b1);
    endtask

    // A watchdog against a hung block: it counts cycles in which nothing moves
    // on either port.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || digest_strobe)
                quiet_cycles <= 0;
            else if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int phase_end;
        int body;
        int pick;

        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        idle_pct = 0;
        words_sent = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed messages, back to back.
        // The empty message: a last word with no valid bytes and junk data.
        send_word(32'hFFFFFFFF, 3'd0, 1'b1);
        // The classic three-byte message, with its unused byte set.
        send_word(32'h616263FF, 3'd3, 1'b1);
        // Partial last words: bytes past the count must be dropped.
        send_word(32'hFFFFFFFF, 3'd1, 1'b1);
        send_word(32'h00000000, 3'd2, 1'b1);
        // A full last word pushes the pad into a word of its own.
        send_word(32'hFFFFFFFF, 3'd4, 1'b1);
        // Byte counts above four saturate to four.
        send_word(32'hA5C3_0F96, 3'd5, 1'b1);
        send_word(32'h5A3C_F069, 3'd6, 1'b1);
        send_word(32'hFFFFFFFF, 3'd7, 1'b1);
        // Thirteen body words and a full last word: the pad lands in slot
        // fourteen, so the length needs a second block.
        for (int i = 0; i < 13; i++)
            send_word((i % 2) ? 32'h00000000 : 32'hFFFFFFFF, 3'($urandom), 1'b0);
        send_word(32'h80000001, 3'd4, 1'b1);

        // Random messages in four phases of sender behavior: no gaps, heavy
        // gaps, no gaps again, and light gaps. Lengths favor short messages
        // and those near the one-block/two-block boundary, with a few that
        // span several blocks.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 62;
                3:       idle_pct = 26;
                default: idle_pct = 0;
            endcase
            phase_end = words_sent + RANDOM_WORDS / 4;
            while (words_sent < phase_end)
            begin
                pick = $urandom_range(9);
                if (pick < 5)
                    body = $urandom_range(0, 15);
                else if (pick < 8)
                    body = $urandom_range(12, 17);
                else
                    body = $urandom_range(18, 40);
                send_message(body, 3'($urandom));
            end
        end

        start <= 1'b0;
        item  <= '0;

        // Every digest word still owed must arrive; the watchdog bounds this.
        while (digests_pending != 0)
            @(posedge clk);
        // Give a stray extra strobe time to show up.
        repeat (30) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
